// ----- hdl/fdtd1d_pkg.sv -----
// Shared constants and types of the 1-D FDTD field update block.
package fdtd1d_pkg;

  // grid size and loop geometry
  localparam int CELLS       = 64;
  localparam int PIPE_STAGES = 6;
  localparam int LOOP_LEN    = CELLS + PIPE_STAGES;
  localparam int CNT_W       = $clog2(LOOP_LEN);

  // field and arithmetic widths
  localparam int IDX_W     = 6;
  localparam int FIELD_W   = 18;
  localparam int COEF_W    = 16;
  localparam int DIFF_W    = FIELD_W + 1;
  localparam int PROD_W    = COEF_W + DIFF_W;
  localparam int RND_SHIFT = 15;
  localparam int RND_W     = PROD_W + 1 - RND_SHIFT;
  localparam int SUM_W     = RND_W + 1;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_E_OUT   = 3'd0,
    REG_COEF_H_OUT   = 3'd1,
    REG_COEF_E_IN    = 3'd2,
    REG_COEF_H_IN    = 3'd3,
    REG_SLAB_FIRST   = 3'd4,
    REG_SLAB_LAST    = 3'd5,
    REG_SOURCE_CELL  = 3'd6,
    REG_SRC_ADD      = 3'd7
  } cfg_reg_t;

  localparam logic signed [COEF_W-1:0] COEF_RESET = -16'sd16384;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_e_out;
    logic signed [COEF_W-1:0] coef_h_out;
    logic signed [COEF_W-1:0] coef_e_in;
    logic signed [COEF_W-1:0] coef_h_in;
    logic [IDX_W-1:0]         slab_first;
    logic [IDX_W-1:0]         slab_last;
    logic [IDX_W-1:0]         source_cell;
    logic                     src_add;
  } cfg_t;

  // E and H of one grid cell
  typedef struct packed {
    logic signed [FIELD_W-1:0] e;
    logic signed [FIELD_W-1:0] h;
  } elem_t;

endpackage

// ----- hdl/fdtd1d_in_if.sv -----
// Input channel: one source sample per time step.
interface fdtd1d_in_if import fdtd1d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] source_value;

  modport source (output valid, output source_value, input ready);
  modport sink   (input valid, input source_value, output ready);
endinterface

// ----- hdl/fdtd1d_out_if.sv -----
// Result channel: E and H of one cell per transfer.
interface fdtd1d_out_if import fdtd1d_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          cell_index;
  logic signed [FIELD_W-1:0] e_value;
  logic signed [FIELD_W-1:0] h_value;
  logic                      last_cell;

  modport source (output valid, output cell_index, output e_value, output h_value,
                  output last_cell, input ready);
  modport sink   (input valid, input cell_index, input e_value, input h_value,
                  input last_cell, output ready);
endinterface

// ----- hdl/fdtd1d_cell.sv -----
// One grid cell of the field ring: holds E and H and passes them on.
module fdtd1d_cell import fdtd1d_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  elem_t d,
  output elem_t q
);

  elem_t q_r;

  // shift in the neighbour's fields on every ring step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (advance) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ----- hdl/fdtd1d_update.sv -----
// Six-stage Yee update unit that sits in the ring, with the edge histories.
module fdtd1d_update import fdtd1d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  cfg_t                      cfg,
  input  logic signed [FIELD_W-1:0] src,
  input  logic                      head_valid,
  input  logic [IDX_W-1:0]          head_idx,
  input  elem_t                     head,
  input  elem_t                     next,
  output elem_t                     tail,
  output logic                      tail_valid,
  output logic [IDX_W-1:0]          tail_idx
);

  typedef struct packed {
    logic                      vld;
    logic [IDX_W-1:0]          idx;
    logic signed [FIELD_W-1:0] e;
    logic signed [FIELD_W-1:0] h;
    logic signed [COEF_W-1:0]  coef;
    logic signed [DIFF_W-1:0]  diff;
  } dstage_t;

  typedef struct packed {
    logic                      vld;
    logic [IDX_W-1:0]          idx;
    logic signed [FIELD_W-1:0] e;
    logic signed [FIELD_W-1:0] h;
    logic signed [PROD_W-1:0]  prod;
  } pstage_t;

  typedef struct packed {
    logic                      vld;
    logic [IDX_W-1:0]          idx;
    logic signed [FIELD_W-1:0] e;
    logic signed [FIELD_W-1:0] h;
  } fstage_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);

  function automatic logic in_slab(input logic [IDX_W-1:0] k,
                                   input logic [IDX_W-1:0] lo,
                                   input logic [IDX_W-1:0] hi);
    return (k >= lo) && (k <= hi);
  endfunction

  // floor((p + 2^14) / 2^15): round to nearest, ties upward
  function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {p[PROD_W-1], p} + (PROD_W+1)'(1 << (RND_SHIFT - 1));
    return s[PROD_W:RND_SHIFT];
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic [SUM_W-1:0] v);
    logic [SUM_W-FIELD_W:0] top;
    top = v[SUM_W-1:FIELD_W-1];
    if (top == '0 || top == '1) begin
      return v[FIELD_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(FIELD_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [FIELD_W-1:0] add_round(input logic signed [FIELD_W-1:0] f,
                                                          input logic signed [PROD_W-1:0] p);
    logic signed [RND_W-1:0] r;
    logic [SUM_W-1:0]        s;
    r = round_q15(p);
    s = {{(SUM_W-FIELD_W){f[FIELD_W-1]}}, f} + {r[RND_W-1], r};
    return sat_field(s);
  endfunction

  dstage_t a_r, a_nxt, d_r, d_nxt;
  pstage_t b_r, b_nxt, e_r, e_nxt;
  fstage_t c_r, c_nxt, f_r, f_nxt;

  logic signed [FIELD_W-1:0] left_r  [3];
  logic signed [FIELD_W-1:0] right_r [3];

  logic signed [FIELD_W-1:0] e_right;
  logic signed [FIELD_W-1:0] h_left;
  logic [SUM_W-1:0]          soft_sum;
  logic                      src_hit;

  // stage A: forward E difference, right edge history beyond the last cell
  always_comb begin
    e_right    = (head_idx == LAST_IDX) ? right_r[2] : next.e;
    a_nxt.vld  = head_valid;
    a_nxt.idx  = head_idx;
    a_nxt.e    = head.e;
    a_nxt.h    = head.h;
    a_nxt.coef = in_slab(head_idx, cfg.slab_first, cfg.slab_last) ?
                 cfg.coef_h_in : cfg.coef_h_out;
    a_nxt.diff = {e_right[FIELD_W-1], e_right} - {head.e[FIELD_W-1], head.e};
  end

  // stage B: H product
  always_comb begin
    b_nxt.vld  = a_r.vld;
    b_nxt.idx  = a_r.idx;
    b_nxt.e    = a_r.e;
    b_nxt.h    = a_r.h;
    b_nxt.prod = a_r.coef * a_r.diff;
  end

  // stage C: new H
  always_comb begin
    c_nxt.vld = b_r.vld;
    c_nxt.idx = b_r.idx;
    c_nxt.e   = b_r.e;
    c_nxt.h   = add_round(b_r.h, b_r.prod);
  end

  // stage D: backward H difference; the previous cell's new H sits in stage D
  always_comb begin
    h_left     = (c_r.idx == '0) ? left_r[1] : d_r.h;
    d_nxt.vld  = c_r.vld;
    d_nxt.idx  = c_r.idx;
    d_nxt.e    = c_r.e;
    d_nxt.h    = c_r.h;
    d_nxt.coef = in_slab(c_r.idx, cfg.slab_first, cfg.slab_last) ?
                 cfg.coef_e_in : cfg.coef_e_out;
    d_nxt.diff = {c_r.h[FIELD_W-1], c_r.h} - {h_left[FIELD_W-1], h_left};
  end

  // stage E: E product
  always_comb begin
    e_nxt.vld  = d_r.vld;
    e_nxt.idx  = d_r.idx;
    e_nxt.e    = d_r.e;
    e_nxt.h    = d_r.h;
    e_nxt.prod = d_r.coef * d_r.diff;
  end

  // stage F: new E before the source
  always_comb begin
    f_nxt.vld = e_r.vld;
    f_nxt.idx = e_r.idx;
    f_nxt.e   = add_round(e_r.e, e_r.prod);
    f_nxt.h   = e_r.h;
  end

  // advance the pipeline with the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
      e_r <= '0;
      f_r <= '0;
    end else if (advance) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      d_r <= d_nxt;
      e_r <= e_nxt;
      f_r <= f_nxt;
    end
  end

  // shift the left history with new H of cell 0, the right one with new E of the last cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        left_r[i]  <= '0;
        right_r[i] <= '0;
      end
    end else if (advance) begin
      if (c_r.vld && c_r.idx == '0) begin
        left_r[2] <= left_r[1];
        left_r[1] <= left_r[0];
        left_r[0] <= c_r.h;
      end
      if (e_r.vld && e_r.idx == LAST_IDX) begin
        right_r[2] <= right_r[1];
        right_r[1] <= right_r[0];
        right_r[0] <= f_nxt.e;
      end
    end
  end

  // apply the source at its cell; a cell number past the grid takes none
  always_comb begin
    src_hit  = f_r.vld && (f_r.idx == cfg.source_cell) &&
               ({1'b0, cfg.source_cell} < (IDX_W+1)'(CELLS));
    soft_sum = {{(SUM_W-FIELD_W){f_r.e[FIELD_W-1]}}, f_r.e} +
               {{(SUM_W-FIELD_W){src[FIELD_W-1]}}, src};
    tail.h   = f_r.h;
    if (!src_hit) begin
      tail.e = f_r.e;
    end else if (cfg.src_add) begin
      tail.e = sat_field(soft_sum);
    end else begin
      tail.e = src;
    end
  end

  assign tail_valid = f_r.vld;
  assign tail_idx   = f_r.idx;

  a_left_hist: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && c_r.vld && c_r.idx == '0) |=> left_r[0] == $past(c_r.h))
    else $error("left edge history missed new H of cell 0");

  a_pipe_order: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && c_r.vld && c_r.idx != '0) |-> (d_r.vld && d_r.idx == c_r.idx - 1'b1))
    else $error("previous cell not in stage D for backward difference");

  a_right_hist: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && e_r.vld && e_r.idx == LAST_IDX) |=> right_r[1] == $past(right_r[0]))
    else $error("right edge history did not shift");

endmodule

// ----- hdl/fdtd_1d_field_update.sv -----
// Top level of the 1-D FDTD field update: cell ring, update unit, control.
//
// Usage: each transfer on in_chan carries the source sample of one time step.
// The block then updates H and E of all CELLS cells and sends one transfer per
// cell on out_chan, cells 0 upward, with last_cell set on the final one.
// The fields live in a ring of CELLS cells that rotates one place per cycle
// through a six-stage update unit while the receiver keeps up; one step is
// CELLS + 6 ring rotations after the cycle that takes the sample. The first
// result of a step passes stages A to F and the output register once its
// sample is taken; the next sample is taken in the cycle after the last
// rotation, while the last result may still wait.
// in_chan.ready is high whenever no step is running.
// A stalled receiver holds the ring and the update unit in place; nothing is
// dropped. Configuration writes on cfg_we/cfg_index/cfg_data take effect at
// once and belong only between steps.
// Reset (rst_n low, synchronous) clears all fields and edge histories to zero
// and loads the register defaults; no clearing pass is needed.
module fdtd_1d_field_update import fdtd1d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  fdtd1d_in_if.sink            in_chan,
  fdtd1d_out_if.source         out_chan,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t                      cfg_r;
  logic                      run_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [FIELD_W-1:0] src_r;
  logic                      advance;
  logic                      in_xfer;

  elem_t                     chain_q [CELLS];
  elem_t                     tail;
  logic                      tail_valid;
  logic [IDX_W-1:0]          tail_idx;
  logic                      head_valid;
  logic [IDX_W-1:0]          head_idx;

  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic signed [FIELD_W-1:0] out_e_r;
  logic signed [FIELD_W-1:0] out_h_r;
  logic                      out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coef_e_out  <= COEF_RESET;
      cfg_r.coef_h_out  <= COEF_RESET;
      cfg_r.coef_e_in   <= COEF_RESET;
      cfg_r.coef_h_in   <= COEF_RESET;
      cfg_r.slab_first  <= '0;
      cfg_r.slab_last   <= '0;
      cfg_r.source_cell <= '0;
      cfg_r.src_add     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_COEF_E_OUT:  cfg_r.coef_e_out  <= cfg_data[COEF_W-1:0];
        REG_COEF_H_OUT:  cfg_r.coef_h_out  <= cfg_data[COEF_W-1:0];
        REG_COEF_E_IN:   cfg_r.coef_e_in   <= cfg_data[COEF_W-1:0];
        REG_COEF_H_IN:   cfg_r.coef_h_in   <= cfg_data[COEF_W-1:0];
        REG_SLAB_FIRST:  cfg_r.slab_first  <= cfg_data[IDX_W-1:0];
        REG_SLAB_LAST:   cfg_r.slab_last   <= cfg_data[IDX_W-1:0];
        REG_SOURCE_CELL: cfg_r.source_cell <= cfg_data[IDX_W-1:0];
        REG_SRC_ADD:     cfg_r.src_add     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // step control: rotate the ring LOOP_LEN times per sample
  assign in_chan.ready = !run_r;
  assign in_xfer       = in_chan.valid && !run_r;
  assign advance       = run_r && (!out_valid_r || out_chan.ready);
  assign head_valid    = cnt_r < CNT_W'(CELLS);
  assign head_idx      = IDX_W'(cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (in_xfer) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (advance) begin
      if (cnt_r == CNT_W'(LOOP_LEN - 1)) begin
        run_r <= 1'b0;
        cnt_r <= '0;
      end else begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // hold the sample for the whole step
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      src_r <= in_chan.source_value;
    end
  end

  // ring of cells; the update unit closes it from cell 0 back to the last cell
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    if (i == CELLS - 1) begin : g_tail
      fdtd1d_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .d       (tail),
        .q       (chain_q[i])
      );
    end else begin : g_body
      fdtd1d_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .d       (chain_q[i+1]),
        .q       (chain_q[i])
      );
    end
  end

  fdtd1d_update u_update (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .cfg        (cfg_r),
    .src        (src_r),
    .head_valid (head_valid),
    .head_idx   (head_idx),
    .head       (chain_q[0]),
    .next       (chain_q[1]),
    .tail       (tail),
    .tail_valid (tail_valid),
    .tail_idx   (tail_idx)
  );

  // output register: load a finished cell, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= tail_valid;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_idx_r  <= tail_idx;
      out_e_r    <= tail.e;
      out_h_r    <= tail.h;
      out_last_r <= (tail_idx == IDX_W'(CELLS - 1));
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.cell_index = out_idx_r;
  assign out_chan.e_value    = out_e_r;
  assign out_chan.h_value    = out_h_r;
  assign out_chan.last_cell  = out_last_r;

  a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (run_r && cnt_r == '0))
    else $error("step did not start after sample transfer");

  a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && cnt_r == CNT_W'(LOOP_LEN - 1)) |=> !run_r)
    else $error("ring kept rotating after a full step");

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_cell) |-> out_chan.cell_index == IDX_W'(CELLS - 1))
    else $error("last_cell flagged on a cell other than the final one");

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench of the 1-D FDTD field update: grid predictor, driver, monitor.
`timescale 1ns / 100ps

module tb_top;
  import fdtd1d_pkg::*;

  typedef logic signed [FIELD_W-1:0] field_t;

  // one expected cell report
  typedef struct {
    logic [IDX_W-1:0] idx;
    field_t           e;
    field_t           h;
    logic             last;
  } cell_result_t;

  typedef enum logic [1:0] {
    STALL_OPEN,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_t;

  localparam longint FIELD_TOP     = (longint'(1) <<< (FIELD_W - 1)) - 1;
  localparam longint FIELD_BOTTOM  = -(longint'(1) <<< (FIELD_W - 1));
  localparam longint ROUND_HALF    = longint'(1) <<< (RND_SHIFT - 1);
  localparam int     SETTLE_CYCLES = PIPE_STAGES + 10;
  localparam int     LONG_HOLD     = 600;
  localparam int     RANDOM_STEPS  = 450;
  localparam int     CYCLE_LIMIT   = 1000000;
  localparam int     PRINT_CAP     = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  fdtd1d_in_if  in_chan ();
  fdtd1d_out_if out_chan ();

  fdtd_1d_field_update dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predicted grid state and register copy
  field_t e_grid [CELLS];
  field_t h_grid [CELLS];
  field_t left_hist [3];
  field_t right_hist [3];
  cfg_t   grid_cfg;

  field_t       source_queue [$];
  cell_result_t cell_results_due [$];

  int steps_queued    = 0;
  int steps_accepted  = 0;
  int results_seen    = 0;
  int mismatches      = 0;
  int clamp_hits      = 0;
  int settings_loaded = 0;
  int hold_epoch      = 0;
  int holds_served    = 0;
  int burst_left      = 0;
  int gap_left        = 0;
  int hold_left       = 0;
  int stall_tick      = 0;
  int cycle_count     = 0;
  stall_mode_t stall_mode = STALL_OPEN;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic field_t clamp_field(longint v);
    if (v > FIELD_TOP) begin
      clamp_hits++;
      return field_t'(FIELD_TOP);
    end
    if (v < FIELD_BOTTOM) begin
      clamp_hits++;
      return field_t'(FIELD_BOTTOM);
    end
    return field_t'(v);
  endfunction

  // f + c * (a - b) / 2^15, rounded half up, then saturated
  function automatic field_t field_update(field_t f, logic signed [COEF_W-1:0] c,
                                          field_t a, field_t b);
    longint prod;
    prod = longint'(c) * (longint'(a) - longint'(b));
    return clamp_field(longint'(f) + ((prod + ROUND_HALF) >>> RND_SHIFT));
  endfunction

  function automatic bit in_slab(int k);
    return k >= grid_cfg.slab_first && k <= grid_cfg.slab_last;
  endfunction

  function automatic void grid_reset();
    foreach (e_grid[k]) begin
      e_grid[k] = '0;
      h_grid[k] = '0;
    end
    foreach (left_hist[k]) begin
      left_hist[k]  = '0;
      right_hist[k] = '0;
    end
    grid_cfg.coef_e_out  = COEF_RESET;
    grid_cfg.coef_h_out  = COEF_RESET;
    grid_cfg.coef_e_in   = COEF_RESET;
    grid_cfg.coef_h_in   = COEF_RESET;
    grid_cfg.slab_first  = '0;
    grid_cfg.slab_last   = '0;
    grid_cfg.source_cell = '0;
    grid_cfg.src_add     = 1'b1;
  endfunction

  // advance the grid by one time step and queue every cell's report
  function automatic void advance_grid(field_t sample);
    cell_result_t r;
    int sc;
    // H from forward E differences, right edge history beyond the last cell
    for (int k = 0; k < CELLS - 1; k++)
      h_grid[k] = field_update(h_grid[k], in_slab(k) ? grid_cfg.coef_h_in : grid_cfg.coef_h_out,
                               e_grid[k + 1], e_grid[k]);
    h_grid[CELLS - 1] = field_update(h_grid[CELLS - 1],
                                     in_slab(CELLS - 1) ? grid_cfg.coef_h_in
                                                        : grid_cfg.coef_h_out,
                                     right_hist[2], e_grid[CELLS - 1]);
    left_hist[2] = left_hist[1];
    left_hist[1] = left_hist[0];
    left_hist[0] = h_grid[0];
    // E from backward H differences, left edge history before cell 0
    e_grid[0] = field_update(e_grid[0], in_slab(0) ? grid_cfg.coef_e_in : grid_cfg.coef_e_out,
                             h_grid[0], left_hist[2]);
    for (int k = 1; k < CELLS; k++)
      e_grid[k] = field_update(e_grid[k], in_slab(k) ? grid_cfg.coef_e_in : grid_cfg.coef_e_out,
                               h_grid[k], h_grid[k - 1]);
    right_hist[2] = right_hist[1];
    right_hist[1] = right_hist[0];
    right_hist[0] = e_grid[CELLS - 1];
    // source: add or overwrite, skipped when the cell lies off the grid
    sc = int'(grid_cfg.source_cell);
    if (sc < CELLS) begin
      if (grid_cfg.src_add)
        e_grid[sc] = clamp_field(longint'(e_grid[sc]) + longint'(sample));
      else
        e_grid[sc] = sample;
    end
    for (int k = 0; k < CELLS; k++) begin
      r.idx  = IDX_W'(k);
      r.e    = e_grid[k];
      r.h    = h_grid[k];
      r.last = (k == CELLS - 1);
      cell_results_due.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic queue_sample(input field_t v);
    source_queue.push_back(v);
    steps_queued++;
  endtask

  // caller is aligned to a clock edge; the write lands on the next one
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t s);
    @(posedge clk);
    write_reg(REG_COEF_E_OUT, s.coef_e_out);
    write_reg(REG_COEF_H_OUT, s.coef_h_out);
    write_reg(REG_COEF_E_IN, s.coef_e_in);
    write_reg(REG_COEF_H_IN, s.coef_h_in);
    write_reg(REG_SLAB_FIRST, CFG_W'(s.slab_first));
    write_reg(REG_SLAB_LAST, CFG_W'(s.slab_last));
    write_reg(REG_SOURCE_CELL, CFG_W'(s.source_cell));
    write_reg(REG_SRC_ADD, CFG_W'(s.src_add));
    cfg_we   <= 1'b0;
    grid_cfg = s;
    settings_loaded++;
  endtask

  // hold until every queued step is taken and every report has arrived
  task automatic wait_quiet();
    while (steps_accepted != steps_queued || cell_results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    int mag;
    mag = $urandom_range(2048, 20000);
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return COEF_W'($urandom);
      4:       return COEF_W'(mag);
      default: return COEF_W'(-mag);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_cell();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return IDX_W'(CELLS - 1);
      default: return IDX_W'($urandom_range(0, CELLS - 1));
    endcase
  endfunction

  function automatic field_t pick_sample();
    int mag;
    mag = $urandom_range(0, 8192);
    case ($urandom_range(0, 9))
      0:       return field_t'(FIELD_TOP);
      1:       return field_t'(FIELD_BOTTOM);
      2, 3:    return FIELD_W'($urandom);
      default: return $urandom_range(0, 1) ? FIELD_W'(mag) : FIELD_W'(-mag);
    endcase
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t s;
    s.coef_e_out = pick_coef();
    s.coef_h_out = pick_coef();
    s.coef_e_in  = pick_coef();
    s.coef_h_in  = pick_coef();
    case ($urandom_range(0, 3))
      0: begin
        // empty slab: first cell beyond the last
        s.slab_first = IDX_W'($urandom_range(1, CELLS - 1));
        s.slab_last  = IDX_W'($urandom_range(0, int'(s.slab_first) - 1));
      end
      1: begin
        s.slab_first = '0;
        s.slab_last  = IDX_W'(CELLS - 1);
      end
      default: begin
        s.slab_first = pick_cell();
        s.slab_last  = pick_cell();
      end
    endcase
    s.source_cell = pick_cell();
    s.src_add     = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // ---------------------------------------------------------------- driver

  // offer queued samples in bursts with random gaps between them
  always @(posedge clk) begin
    logic offering;
    if (!rst_n) begin
      in_chan.valid        <= 1'b0;
      in_chan.source_value <= '0;
    end else begin
      offering = in_chan.valid;
      if (in_chan.valid && in_chan.ready) begin
        advance_grid(in_chan.source_value);
        steps_accepted++;
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (source_queue.size() > 0) begin
          if (burst_left == 0) burst_left = $urandom_range(1, 8);
          in_chan.source_value <= source_queue.pop_front();
          offering = 1'b1;
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end
      end
      in_chan.valid <= offering;
    end
  end

  // ---------------------------------------------------------------- monitor

  // check each cell transfer against the oldest expected report
  always @(posedge clk) begin
    cell_result_t want;
    logic         take;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        results_seen++;
        if (cell_results_due.size() == 0) begin
          note_mismatch($sformatf("unexpected transfer for cell %0d", out_chan.cell_index));
        end else begin
          want = cell_results_due.pop_front();
          if (out_chan.cell_index !== want.idx)
            note_mismatch($sformatf("cell_index got %0d want %0d",
                                    out_chan.cell_index, want.idx));
          if (out_chan.e_value !== want.e)
            note_mismatch($sformatf("cell %0d e_value got %0d want %0d",
                                    want.idx, out_chan.e_value, want.e));
          if (out_chan.h_value !== want.h)
            note_mismatch($sformatf("cell %0d h_value got %0d want %0d",
                                    want.idx, out_chan.h_value, want.h));
          if (out_chan.last_cell !== want.last)
            note_mismatch($sformatf("cell %0d last_cell got %0b want %0b",
                                    want.idx, out_chan.last_cell, want.last));
        end
      end
      // pick a new stall pattern at random, on a period set by stall_tick
      stall_tick++;
      if (stall_tick % 150 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
      if (hold_epoch != holds_served) begin
        holds_served = hold_epoch;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case (stall_mode)
          STALL_OPEN:  take = 1'b1;
          STALL_LIGHT: take = ($urandom_range(0, 3) != 0);
          STALL_HEAVY: take = ($urandom_range(0, 3) == 0);
          default:     take = (stall_tick % 7) >= 3;
        endcase
      end
      out_chan.ready <= take;
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycle_count, cell_results_due.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    cfg_t s;
    int   random_steps;
    int   phase_no;
    int   n;
    grid_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: soft source at cell 0, field extremes
    queue_sample(field_t'(FIELD_TOP));
    queue_sample(field_t'(FIELD_BOTTOM));
    queue_sample('0);
    queue_sample(FIELD_W'(1));
    queue_sample(FIELD_W'(-1));
    queue_sample('0);
    wait_quiet();

    // largest positive coefficients across a full slab, hard source on the last cell
    s.coef_e_out = 16'h7fff; s.coef_h_out = 16'h7fff;
    s.coef_e_in  = 16'h7fff; s.coef_h_in  = 16'h7fff;
    s.slab_first = '0; s.slab_last = IDX_W'(CELLS - 1);
    s.source_cell = IDX_W'(CELLS - 1); s.src_add = 1'b0;
    load_settings(s);
    queue_sample(field_t'(FIELD_TOP));
    queue_sample(field_t'(FIELD_BOTTOM));
    queue_sample(18'h2aaaa);
    queue_sample(18'h15555);
    wait_quiet();

    // most negative coefficient, empty slab, soft source driven into saturation
    s.coef_e_out = 16'h8000; s.coef_h_out = 16'h0000;
    s.coef_e_in  = 16'h8000; s.coef_h_in  = 16'h7fff;
    s.slab_first = IDX_W'(40); s.slab_last = IDX_W'(10);
    s.source_cell = IDX_W'(31); s.src_add = 1'b1;
    load_settings(s);
    repeat (3) queue_sample(field_t'(FIELD_TOP));
    repeat (3) queue_sample(field_t'(FIELD_BOTTOM));
    wait_quiet();

    // zero coefficients leave the fields still; single-cell slab, hard source at cell 0
    s.coef_e_out = '0; s.coef_h_out = '0; s.coef_e_in = '0; s.coef_h_in = '0;
    s.slab_first = IDX_W'(20); s.slab_last = IDX_W'(20);
    s.source_cell = '0; s.src_add = 1'b0;
    load_settings(s);
    queue_sample(FIELD_W'(1234));
    queue_sample(FIELD_W'(-4321));
    queue_sample('0);
    queue_sample(field_t'(FIELD_TOP));
    queue_sample(field_t'(FIELD_BOTTOM));
    wait_quiet();

    // random phases, each under fresh settings
    random_steps = 0;
    phase_no     = 0;
    while (random_steps < RANDOM_STEPS) begin
      load_settings(pick_settings());
      n = $urandom_range(25, 55);
      if (n > RANDOM_STEPS - random_steps) n = RANDOM_STEPS - random_steps;
      for (int i = 0; i < n; i++) queue_sample(pick_sample());
      random_steps += n;
      // hold the receiver off while samples keep coming
      if (phase_no % 5 == 2) hold_epoch++;
      phase_no++;
      wait_quiet();
    end

    wait_quiet();
    repeat (LOOP_LEN) @(posedge clk);
    $display("Run covered %0d time steps and %0d cell transfers under %0d register settings,",
             steps_accepted, results_seen, settings_loaded + 1);
    $display("with %0d long receiver hold-offs and %0d predicted saturations.",
             holds_served, clamp_hits);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
